### rtl/core/rkl_pkg.sv
package rkl_pkg;

  // Sizes of the stores and of the arithmetic.
  localparam int MAX_DIM   = 32;
  localparam int IDX_W     = 5;
  localparam int DIM_W     = 6;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = 48;
  localparam int WSUM_W    = 35;
  localparam int DIV_W     = 36;
  localparam int DIG_W     = 12;
  localparam int DIV_STEPS = DIV_W / DIG_W;
  localparam int DIV_CNT_W = 2;
  localparam int RECIP_W   = 16;
  localparam int RECIP_SH  = 17;
  localparam int QUO_W     = 36;

  localparam logic [DIM_W-1:0]   DIM_RESET = DIM_W'(MAX_DIM);
  // Reciprocal of three scaled by 2^17, rounded up.
  localparam logic [RECIP_W-1:0] RECIP3    = 16'hAAAB;

  // Input action codes.
  typedef enum logic [1:0] {
    ACT_WR_MAT = 2'd0,
    ACT_WR_VEC = 2'd1,
    ACT_RUN    = 2'd2
  } action_e;

  // Weight applied to the stage vector when forming operands or sums.
  typedef enum logic [1:0] {
    WT_NONE,
    WT_HALF,
    WT_FULL,
    WT_TWO
  } wt_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FORM,
    ST_MAC,
    ST_DRAIN,
    ST_WACC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]               action;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] result;
    logic                     last;
  } out_word_t;

  // Contents of one cell of the chain.
  typedef struct packed {
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] k;
    logic signed [WSUM_W-1:0] w;
  } cell_data_t;

  // Commands broadcast to every cell.
  typedef struct packed {
    logic                     y_we;
    logic [IDX_W-1:0]         y_idx;
    logic signed [DATA_W-1:0] y_val;
    logic                     rot_a;
    logic                     rot_yw;
    logic                     shift_k;
    logic                     clear;
    logic                     form;
    wt_e                      form_wt;
    logic                     add_w;
    wt_e                      add_wt;
  } cell_ctrl_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic use_col;
    logic use_row;
  } mac_issue_t;

  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] value;
  } k_push_t;

  // Saturate to 32 bits.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sh7FFF_FFFF);
    lo = -hi - ACC_W'(1);
    if (x > hi) return hi[DATA_W-1:0];
    if (x < lo) return lo[DATA_W-1:0];
    return x[DATA_W-1:0];
  endfunction

  // Saturate a grown accumulator sum back to 48 bits.
  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W:0] x);
    if (x[ACC_W] != x[ACC_W-1]) return {x[ACC_W], {(ACC_W-1){~x[ACC_W]}}};
    return x[ACC_W-1:0];
  endfunction

endpackage

### rtl/core/rkl_cell.sv
module rkl_cell import rkl_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] cell_idx,
  input  cell_ctrl_t       ctrl,
  input  cell_data_t       nbr,
  output cell_data_t       own
);

  logic signed [DATA_W-1:0] y_r, y_nxt;
  logic signed [DATA_W-1:0] a_r, a_nxt;
  logic signed [DATA_W-1:0] k_r, k_nxt;
  logic signed [WSUM_W-1:0] w_r, w_nxt;
  logic signed [DATA_W-1:0] k_add;
  logic signed [WSUM_W-1:0] w_inc;

  // Operand for the next stage: y plus none, half or all of the last stage.
  always_comb begin
    case (ctrl.form_wt)
      WT_HALF: k_add = k_r >>> 1;
      WT_FULL: k_add = k_r;
      default: k_add = '0;
    endcase
    w_inc = (ctrl.add_wt == WT_TWO) ? (WSUM_W'(k_r) <<< 1) : WSUM_W'(k_r);
  end

  // Next values; the rings hand each field to the neighbor toward cell zero.
  always_comb begin
    y_nxt = y_r;
    if (ctrl.y_we && ctrl.y_idx == cell_idx) y_nxt = ctrl.y_val;
    else if (ctrl.rot_yw) y_nxt = nbr.y;

    a_nxt = a_r;
    if (ctrl.form) a_nxt = sat32(ACC_W'(y_r) + ACC_W'(k_add));
    else if (ctrl.rot_a) a_nxt = nbr.a;

    k_nxt = k_r;
    if (ctrl.clear) k_nxt = '0;
    else if (ctrl.shift_k) k_nxt = nbr.k;

    w_nxt = w_r;
    if (ctrl.clear) w_nxt = '0;
    else if (ctrl.add_w) w_nxt = w_r + w_inc;
    else if (ctrl.rot_yw) w_nxt = nbr.w;
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
    a_r <= a_nxt;
    k_r <= k_nxt;
    w_r <= w_nxt;
  end

  assign own = '{y: y_r, a: a_r, k: k_r, w: w_r};

endmodule

### rtl/core/rkl_mac.sv
module rkl_mac import rkl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mem_wr_t                  wr,
  input  mac_issue_t               issue,
  input  logic [ADDR_W-1:0]        raddr,
  input  logic signed [DATA_W-1:0] a_val,
  output k_push_t                  push,
  output logic                     busy
);

  logic signed [DATA_W-1:0] mem [MAT_DEPTH];
  logic signed [DATA_W-1:0] rdata_r;
  logic signed [DATA_W-1:0] a1_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  term, base;
  mac_issue_t               s1_r, s2_r;

  // Coefficient store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr] <= wr.data;
    rdata_r <= mem[raddr];
  end

  // Product of coefficient and operand, then the scaled term is accumulated.
  always_comb begin
    prod_nxt = PROD_W'(rdata_r) * PROD_W'(a1_r);
    term     = s2_r.use_col ? ACC_W'(prod_r >>> FRAC_BITS) : '0;
    base     = s2_r.first ? '0 : acc_r;
    acc_nxt  = sat48((ACC_W + 1)'(base) + (ACC_W + 1)'(term));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else begin
      s1_r <= issue;
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r   <= a_val;
    prod_r <= prod_nxt;
    if (s2_r.vld) acc_r <= acc_nxt;
  end

  // A finished row goes into the tail of the stage ring.
  assign push.vld   = s2_r.vld && s2_r.last;
  assign push.value = s2_r.use_row ? sat32(acc_nxt) : '0;
  assign busy       = s1_r.vld || s2_r.vld;

endmodule

### rtl/core/rkl_div3.sv
module rkl_div3 import rkl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [WSUM_W-1:0] wsum,
  output logic                     done,
  output logic signed [QUO_W-1:0]  quo
);

  // floor((w+3)/6) = floor(floor((w+3)/2)/3); an offset of 3*2^33 keeps it positive.
  localparam logic [WSUM_W-1:0]       U_OFFS = WSUM_W'(64'h6_0000_0000);
  localparam logic signed [QUO_W-1:0] Q_OFFS = QUO_W'(64'sh2_0000_0000);

  logic signed [WSUM_W:0]   d;
  logic [WSUM_W-1:0]        u_sum;
  logic [DIV_W-1:0]         u_r, u_nxt;
  logic [DIV_W-1:0]         q_r, q_nxt;
  logic [1:0]               rem_r, rem_nxt;
  logic [DIG_W+1:0]         x;
  logic [DIG_W+RECIP_W+1:0] prod;
  logic [DIG_W-1:0]         qd;
  logic [DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;

  // Long division by three, one twelve-bit digit per cycle, most significant first.
  // Each digit with the carried remainder stays below 2^17, where the reciprocal
  // multiplication gives the exact quotient digit.
  always_comb begin
    d       = (WSUM_W + 1)'(wsum) + (WSUM_W + 1)'(3);
    u_sum   = d[WSUM_W:1] + U_OFFS;
    x       = {rem_r, u_r[DIV_W-1 -: DIG_W]};
    prod    = (DIG_W + RECIP_W + 2)'(x) * (DIG_W + RECIP_W + 2)'(RECIP3);
    qd      = prod[RECIP_SH +: DIG_W];
    u_nxt = u_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      u_nxt = {1'b0, u_sum};
      q_nxt = '0;
      rem_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      u_nxt   = u_r << DIG_W;
      q_nxt   = {q_r[DIV_W-DIG_W-1:0], qd};
      rem_nxt = 2'(x - (DIG_W + 2)'({qd, 1'b0}) - (DIG_W + 2)'(qd));
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r   <= u_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quo  = $signed(q_r) - Q_OFFS;

endmodule

### rtl/core/rk4_linear_system_step.sv
// One classical RK4 step for y' = H*y with the time step folded into H.
// Input channel (in_valid/in_ready/in_word): a word writes a matrix entry,
// writes a state element, or starts a run.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) sets the dimension;
// write it only while the block is idle.
// A run forms four stages on one shared multiply-accumulate unit fed from
// the coefficient memory, one product per cycle over a full 32 by 32 sweep.
// The state, operand, stage and sum vectors live in a ring of 32 cells.
// Each element is then divided by six in a unit that takes twelve bits a
// cycle, for all 32 cells.
// Results leave through out_valid/out_ready/out_word, one word per element,
// with last set on the final one. A stalled receiver holds the result
// register and pauses the run; in_ready stays low until the run ends.
// Reset (rst_n, synchronous) returns to idle with the dimension at 32;
// matrix and vector contents are not cleared and must be written first.
module rk4_linear_system_step import rkl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [DIM_W-1:0] cfg_data
);

  state_e              state_r, state_nxt;
  logic [DIM_W-1:0]    dim_r;
  logic [DIM_W-1:0]    n_eff;
  logic [DIM_W-1:0]    n_run_r;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]          pass_r, pass_nxt;
  logic                drain_r, drain_nxt;
  logic                in_acc;
  logic                out_valid_r;
  out_word_t           out_word_r;
  logic                out_load;
  logic                advance;
  logic                skip;
  logic [IDX_W-1:0]    elem;
  logic [IDX_W-1:0]    i_idx;
  logic [IDX_W-1:0]    j_idx;
  cell_ctrl_t          ctrl;
  cell_data_t          cell_q [MAX_DIM];
  cell_data_t          nbr_d  [MAX_DIM];
  mac_issue_t          issue;
  mem_wr_t             wr;
  k_push_t             push;
  logic                mac_busy;
  logic                div_start;
  logic                div_done;
  logic signed [QUO_W-1:0]  quo;
  logic signed [DATA_W-1:0] res;

  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign elem      = cnt_r[IDX_W-1:0];
  assign i_idx     = cnt_r[IDX_W-1:0];
  assign j_idx     = cnt_r[ADDR_W-1:IDX_W];
  assign skip      = ({1'b0, elem} >= n_run_r);
  assign advance   = skip || !out_valid_r || out_ready;
  assign res       = sat32(ACC_W'(cell_q[0].y) + ACC_W'(quo));

  // Dimension in use: zero acts as one, larger values clamp to the store.
  always_comb begin
    if (dim_r == '0) n_eff = DIM_W'(1);
    else if (dim_r > DIM_W'(MAX_DIM)) n_eff = DIM_W'(MAX_DIM);
    else n_eff = dim_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_acc && in_word.action == ACT_RUN) state_nxt = ST_CLEAR;
      ST_CLEAR:     state_nxt = ST_FORM;
      ST_FORM:      state_nxt = ST_MAC;
      ST_MAC:       if (cnt_r == '1) state_nxt = ST_DRAIN;
      ST_DRAIN:     if (drain_r) state_nxt = ST_WACC;
      ST_WACC:      state_nxt = (pass_r == 2'd3) ? ST_DIV_START : ST_FORM;
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (advance) state_nxt = (elem == '1) ? ST_IDLE : ST_DIV_START;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    ctrl = '0;
    ctrl.y_idx = in_word.row;
    ctrl.y_val = in_word.value;
    ctrl.form_wt = WT_NONE;
    ctrl.add_wt = WT_FULL;
    issue = '0;
    div_start = 1'b0;
    out_load = 1'b0;
    in_ready = 1'b0;
    wr.we = 1'b0;
    wr.addr = {in_word.row, in_word.col};
    wr.data = in_word.value;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctrl.y_we = in_acc && in_word.action == ACT_WR_VEC;
        wr.we = in_acc && in_word.action == ACT_WR_MAT;
      end
      ST_CLEAR: ctrl.clear = 1'b1;
      ST_FORM: begin
        ctrl.form = 1'b1;
        case (pass_r)
          2'd0:    ctrl.form_wt = WT_NONE;
          2'd3:    ctrl.form_wt = WT_FULL;
          default: ctrl.form_wt = WT_HALF;
        endcase
      end
      ST_MAC: begin
        ctrl.rot_a = 1'b1;
        issue.vld = 1'b1;
        issue.first = (i_idx == '0);
        issue.last = (i_idx == '1);
        issue.use_col = ({1'b0, i_idx} < n_run_r);
        issue.use_row = ({1'b0, j_idx} < n_run_r);
      end
      ST_WACC: begin
        ctrl.add_w = 1'b1;
        ctrl.add_wt = (pass_r == 2'd1 || pass_r == 2'd2) ? WT_TWO : WT_FULL;
      end
      ST_DIV_START: div_start = 1'b1;
      ST_EMIT: begin
        ctrl.rot_yw = advance;
        out_load = advance && !skip;
      end
      default: ;
    endcase
    ctrl.shift_k = push.vld;
  end

  // Counters of the sequencer.
  always_comb begin
    cnt_nxt = cnt_r;
    pass_nxt = pass_r;
    drain_nxt = 1'b0;
    case (state_r)
      ST_CLEAR: pass_nxt = '0;
      ST_FORM:  cnt_nxt = '0;
      ST_MAC:   cnt_nxt = cnt_r + ADDR_W'(1);
      ST_DRAIN: drain_nxt = !drain_r;
      ST_WACC: begin
        pass_nxt = pass_r + 2'd1;
        cnt_nxt = '0;
      end
      ST_EMIT:  if (advance) cnt_nxt = cnt_r + ADDR_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dim_r <= DIM_RESET;
      n_run_r <= DIM_W'(MAX_DIM);
      cnt_r <= '0;
      pass_r <= '0;
      drain_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      pass_r <= pass_nxt;
      drain_r <= drain_nxt;
      if (cfg_valid && cfg_ready) dim_r <= cfg_data;
      if (in_acc && in_word.action == ACT_RUN) n_run_r <= n_eff;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r.index <= elem;
      out_word_r.result <= res;
      out_word_r.last <= ({1'b0, elem} == n_run_r - DIM_W'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Ring of cells; the tail takes the head's vectors back and new stage values.
  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    if (g == MAX_DIM - 1) begin : g_tail
      assign nbr_d[g] = '{y: cell_q[0].y, a: cell_q[0].a, k: push.value, w: cell_q[0].w};
    end else begin : g_mid
      assign nbr_d[g] = cell_q[g + 1];
    end
    rkl_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(g)),
      .ctrl     (ctrl),
      .nbr      (nbr_d[g]),
      .own      (cell_q[g])
    );
  end

  rkl_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .issue (issue),
    .raddr (cnt_r),
    .a_val (cell_q[0].a),
    .push  (push),
    .busy  (mac_busy)
  );

  rkl_div3 u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .wsum  (cell_q[0].w),
    .done  (div_done),
    .quo   (quo)
  );

  // A result word always names an element inside the run's dimension.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_word_r.index} < n_run_r))
    else $error("result index beyond dimension");

  // The last mark sits on the final element only.
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.last) |-> ({1'b0, out_word_r.index} + DIM_W'(1) == n_run_r))
    else $error("last mark on wrong element");

  // The weighted sum is taken only after the product pipeline has drained.
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WACC) |-> !mac_busy)
    else $error("weighted sum before pipeline drained");

  // A word is emitted only from a finished quotient.
  a_div_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> div_done)
    else $error("result loaded before division finished");

endmodule
